// ===== rtl/assert_macros.svh =====
// assert_macros.svh
// Concurrent assertion helpers for the spin sweep RTL; expects clk and rst in scope.
// No other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checked on every edge outside reset.
`define ISS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Checked on every edge, reset included.
`define ISS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ISS_ASSERT(lbl, prop, msg)
`define ISS_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// ===== rtl/iss_pkg.sv =====
// iss_pkg.sv
// Shared types and constants of the Ising spin sweep block.
// No dependencies.
`default_nettype none

package iss_pkg;

  localparam int SIZE_W     = 11;
  localparam int THR_W      = 32;
  localparam int WORD_W     = 32;
  localparam int OUT_XY_W   = 10;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = 3;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_GRID_WIDTH  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_GRID_HEIGHT = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ZERO_THR    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_BORDER_THR  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SPONT_THR   = 3'd4;

  // reset values
  localparam logic [SIZE_W-1:0] SIZE_RESET       = 11'd3;
  localparam logic [SIZE_W-1:0] SIZE_MIN         = 11'd3;
  localparam logic [SIZE_W-1:0] BORDER_COLS      = 11'd2;
  localparam logic [THR_W-1:0]  ZERO_THR_RESET   = 32'd2147483647;
  localparam logic [THR_W-1:0]  BORDER_THR_RESET = 32'd0;
  localparam logic [THR_W-1:0]  SPONT_THR_RESET  = 32'd0;

  // init: spin goes down when the word is below this
  localparam logic [WORD_W-1:0] INIT_LIMIT = 32'd2147483647;

  // commands
  localparam logic CMD_INIT   = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;

  // neighbors agreeing with the spin: 2 -> e=0, 3 -> e=2, 4 -> e=4, below 2 -> e<0
  localparam logic [2:0] NBR_COUNT  = 3'd4;
  localparam logic [2:0] AGREE_E0   = 3'd2;
  localparam logic [2:0] AGREE_E2   = 3'd3;

  typedef struct packed {
    logic [SIZE_W-1:0] grid_width;
    logic [SIZE_W-1:0] grid_height;
    logic [THR_W-1:0]  zero_thr;
    logic [THR_W-1:0]  border_thr;
    logic [THR_W-1:0]  spont_thr;
    logic              restart;     // size register written this cycle
  } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/iss_in_if.sv =====
// iss_in_if.sv
// Request channel into the spin sweep: command and random word.
// Depends on iss_pkg.
`default_nettype none

interface iss_in_if;
  logic                      valid;
  logic                      ready;
  logic                      cmd;
  logic [iss_pkg::WORD_W-1:0] random_word;

  modport source (output valid, output cmd, output random_word, input ready);
  modport sink (input valid, input cmd, input random_word, output ready);
endinterface

`default_nettype wire

// ===== rtl/iss_out_if.sv =====
// iss_out_if.sv
// Result channel out of the spin sweep: visited site and its new spin.
// Depends on iss_pkg.
`default_nettype none

interface iss_out_if;
  logic                        valid;
  logic                        ready;
  logic [iss_pkg::OUT_XY_W-1:0] site_x;
  logic [iss_pkg::OUT_XY_W-1:0] site_y;
  logic                        spin_up;
  logic                        flipped;
  logic                        last_of_sweep;

  modport source (output valid, output site_x, output site_y, output spin_up,
                  output flipped, output last_of_sweep, input ready);
  modport sink (input valid, input site_x, input site_y, input spin_up,
                input flipped, input last_of_sweep, output ready);
endinterface

`default_nettype wire

// ===== rtl/iss_cfg.sv =====
// iss_cfg.sv
// APB-style register file: grid size and the three flip thresholds.
// Depends on iss_pkg.
`default_nettype none

module iss_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [iss_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [iss_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [iss_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready,
  output iss_pkg::cfg_t                     cfg
);

  logic [iss_pkg::REG_IDX_W-1:0] idx;
  logic                          wr;
  logic [iss_pkg::SIZE_W-1:0]    grid_width;
  logic [iss_pkg::SIZE_W-1:0]    grid_height;
  logic [iss_pkg::THR_W-1:0]     zero_thr;
  logic [iss_pkg::THR_W-1:0]     border_thr;
  logic [iss_pkg::THR_W-1:0]     spont_thr;

  assign idx    = paddr[iss_pkg::CFG_ADDR_W-1:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= iss_pkg::SIZE_RESET;
      grid_height <= iss_pkg::SIZE_RESET;
      zero_thr    <= iss_pkg::ZERO_THR_RESET;
      border_thr  <= iss_pkg::BORDER_THR_RESET;
      spont_thr   <= iss_pkg::SPONT_THR_RESET;
    end else if (wr) begin
      case (idx)
        iss_pkg::REG_GRID_WIDTH:  grid_width  <= pwdata[iss_pkg::SIZE_W-1:0];
        iss_pkg::REG_GRID_HEIGHT: grid_height <= pwdata[iss_pkg::SIZE_W-1:0];
        iss_pkg::REG_ZERO_THR:    zero_thr    <= pwdata[iss_pkg::THR_W-1:0];
        iss_pkg::REG_BORDER_THR:  border_thr  <= pwdata[iss_pkg::THR_W-1:0];
        iss_pkg::REG_SPONT_THR:   spont_thr   <= pwdata[iss_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      iss_pkg::REG_GRID_WIDTH:  prdata = iss_pkg::CFG_DATA_W'(grid_width);
      iss_pkg::REG_GRID_HEIGHT: prdata = iss_pkg::CFG_DATA_W'(grid_height);
      iss_pkg::REG_ZERO_THR:    prdata = zero_thr;
      iss_pkg::REG_BORDER_THR:  prdata = border_thr;
      iss_pkg::REG_SPONT_THR:   prdata = spont_thr;
      default:                  prdata = '0;
    endcase
  end

  always_comb begin
    cfg.grid_width  = grid_width;
    cfg.grid_height = grid_height;
    cfg.zero_thr    = zero_thr;
    cfg.border_thr  = border_thr;
    cfg.spont_thr   = spont_thr;
    cfg.restart     = wr && (idx == iss_pkg::REG_GRID_WIDTH ||
                             idx == iss_pkg::REG_GRID_HEIGHT);
  end

endmodule

`default_nettype wire

// ===== rtl/iss_spin_ram.sv =====
// iss_spin_ram.sv
// Spin store: one bit per site, one write port and two registered read ports.
// No dependencies.
`default_nettype none

module iss_spin_ram #(
  parameter int AW = 20
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic          wr_data,
  input  logic          rd_en_a,
  input  logic [AW-1:0] rd_addr_a,
  output logic          rd_data_a,
  input  logic          rd_en_b,
  input  logic [AW-1:0] rd_addr_b,
  output logic          rd_data_b
);

  logic mem [2**AW];

  // reads return the old contents on a same-cycle write
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en_a) rd_data_a <= mem[rd_addr_a];
    if (rd_en_b) rd_data_b <= mem[rd_addr_b];
  end

endmodule

`default_nettype wire

// ===== rtl/iss_line_ram.sv =====
// iss_line_ram.sv
// Line store of the row finished last, one bit per column, registered read.
// No dependencies.
`default_nettype none

module iss_line_ram #(
  parameter int AW = 10
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic          wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic          rd_data
);

  logic mem [2**AW];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== rtl/ising_spin_sweep.sv =====
// ising_spin_sweep.sv
// Top level: raster sweep of a 2D Ising grid with a +1 border ring.
// Depends on iss_pkg, iss_in_if, iss_out_if, iss_cfg, iss_spin_ram, iss_line_ram.
//
//   channel  dir  handshake          payload
//   in_ch    in   valid/ready        cmd, random_word
//   out_ch   out  valid/ready        site_x, site_y, spin_up, flipped, last_of_sweep
//   apb      in   psel/penable       paddr, pwdata, prdata (pready tied high)
//
// One site per cycle sustained while out_ch is ready; the accepting edge issues the spin
// store reads, stage 1 updates, and its fire writes back and loads the result register.
// The spin store read port A fetches the next site's own spin, which is also the
// right neighbor; port B fetches the down neighbor; the line store gives the up one.
// After reset or a grid size write the block fetches the first site in its prime_issue
// and prime_rd steps before in_ch.ready rises. A stalled out_ch holds one result and one site
// in flight; further requests wait.
`default_nettype none
`include "assert_macros.svh"

module ising_spin_sweep #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  iss_in_if.sink                         in_ch,
  iss_out_if.source                      out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [iss_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [iss_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [iss_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int AW = XW + YW;

  iss_pkg::cfg_t cfg;

  iss_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // last interior column/row after clamping the size to [3, MAX]
  logic [XW-1:0] last_x, last_x_next;
  logic [YW-1:0] last_y, last_y_next;

  always_comb begin
    if (cfg.grid_width < iss_pkg::SIZE_MIN) last_x_next = XW'(1);
    else if (32'(cfg.grid_width) > 32'(MAX_WIDTH)) last_x_next = XW'(MAX_WIDTH - 2);
    else last_x_next = XW'(cfg.grid_width - iss_pkg::BORDER_COLS);
    if (cfg.grid_height < iss_pkg::SIZE_MIN) last_y_next = YW'(1);
    else if (32'(cfg.grid_height) > 32'(MAX_HEIGHT)) last_y_next = YW'(MAX_HEIGHT - 2);
    else last_y_next = YW'(cfg.grid_height - iss_pkg::BORDER_COLS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_x <= XW'(1);
      last_y <= YW'(1);
    end else begin
      last_x <= last_x_next;
      last_y <= last_y_next;
    end
  end

  // ---------------- control ----------------
  logic          primed, prime_rd, prime_issue;
  logic          in_ready, in_fire;
  logic          s1_valid, s1_fire;
  logic          out_valid;
  logic [XW-1:0] cur_x, next_x;
  logic [YW-1:0] cur_y, next_y, down_y;
  logic          row_end, col_end, same_next;
  logic [AW-1:0] addr_a, addr_b, addr_s1;

  // stage 1 payload
  logic                        s1_cmd;
  logic [iss_pkg::WORD_W-1:0]  s1_word;
  logic [XW-1:0]               s1_x;
  logic [YW-1:0]               s1_y;
  logic                        s1_first_col, s1_first_row;
  logic                        s1_row_end, s1_col_end, s1_same;
  logic                        s1_hit_a, s1_hit_b, s1_hit_u, s1_fwd;

  logic rd_a, rd_b, rd_u;
  logic rd_a_eff, up_nb, down_nb, left_nb, right_nb;
  logic own_spin, prev_spin;
  logic [2:0] nbr_up, agree;
  logic [iss_pkg::THR_W-1:0] thr;
  logic flip, new_spin, flipped;

  assign prime_issue = !primed && !prime_rd;
  assign s1_fire     = s1_valid && (!out_valid || out_ch.ready);
  assign in_ready    = primed && (!s1_valid || s1_fire);
  assign in_fire     = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  assign row_end   = (cur_x == last_x);
  assign col_end   = (cur_y == last_y);
  assign next_x    = row_end ? XW'(1) : cur_x + XW'(1);
  assign next_y    = row_end ? (col_end ? YW'(1) : cur_y + YW'(1)) : cur_y;
  assign same_next = (next_x == cur_x) && (next_y == cur_y);
  assign down_y    = cur_y + YW'(1);

  // port A: own spin of the next site (priming: of the current one)
  assign addr_a  = primed ? {next_y, next_x} : {cur_y, cur_x};
  assign addr_b  = {down_y, cur_x};
  assign addr_s1 = {s1_y, s1_x};

  always_ff @(posedge clk) begin
    if (rst) begin
      primed   <= 1'b0;
      prime_rd <= 1'b0;
    end else if (cfg.restart) begin
      primed   <= 1'b0;
      prime_rd <= 1'b0;
    end else if (prime_issue) begin
      prime_rd <= 1'b1;
    end else if (prime_rd) begin
      primed   <= 1'b1;
      prime_rd <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x <= XW'(1);
      cur_y <= YW'(1);
    end else if (cfg.restart) begin
      cur_x <= XW'(1);
      cur_y <= YW'(1);
    end else if (in_fire) begin
      cur_x <= next_x;
      cur_y <= next_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else if (in_fire) s1_valid <= 1'b1;
    else if (s1_fire) s1_valid <= 1'b0;
  end

  // the site in stage 1 is written at this same edge: forward it
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd       <= in_ch.cmd;
      s1_word      <= in_ch.random_word;
      s1_x         <= cur_x;
      s1_y         <= cur_y;
      s1_first_col <= (cur_x == XW'(1));
      s1_first_row <= (cur_y == YW'(1));
      s1_row_end   <= row_end;
      s1_col_end   <= col_end;
      s1_same      <= same_next;
      s1_hit_a     <= s1_fire && (addr_a == addr_s1);
      s1_hit_b     <= s1_fire && (addr_b == addr_s1);
      s1_hit_u     <= s1_fire && (cur_x == s1_x);
      s1_fwd       <= new_spin;
    end
  end

  iss_spin_ram #(.AW(AW)) u_spin (
    .clk       (clk),
    .wr_en     (s1_fire),
    .wr_addr   (addr_s1),
    .wr_data   (new_spin),
    .rd_en_a   (in_fire || prime_issue),
    .rd_addr_a (addr_a),
    .rd_data_a (rd_a),
    .rd_en_b   (in_fire),
    .rd_addr_b (addr_b),
    .rd_data_b (rd_b)
  );

  iss_line_ram #(.AW(XW)) u_line (
    .clk     (clk),
    .wr_en   (s1_fire),
    .wr_addr (s1_x),
    .wr_data (new_spin),
    .rd_en   (in_fire),
    .rd_addr (cur_x),
    .rd_data (rd_u)
  );

  // ---------------- stage 1: update ----------------
  assign rd_a_eff = s1_hit_a ? s1_fwd : rd_a;
  assign right_nb = s1_row_end ? 1'b1 : rd_a_eff;
  assign down_nb  = s1_col_end ? 1'b1 : (s1_hit_b ? s1_fwd : rd_b);
  assign up_nb    = s1_first_row ? 1'b1 : (s1_hit_u ? s1_fwd : rd_u);
  assign left_nb  = s1_first_col ? 1'b1 : prev_spin;

  assign nbr_up = 3'(up_nb) + 3'(down_nb) + 3'(left_nb) + 3'(right_nb);
  assign agree  = own_spin ? nbr_up : iss_pkg::NBR_COUNT - nbr_up;

  always_comb begin
    case (agree)
      iss_pkg::AGREE_E0: thr = cfg.zero_thr;
      iss_pkg::AGREE_E2: thr = cfg.border_thr;
      default:           thr = cfg.spont_thr;
    endcase
  end

  assign flip = (agree < iss_pkg::AGREE_E0) || (s1_word < thr);

  always_comb begin
    if (s1_cmd == iss_pkg::CMD_UPDATE) begin
      new_spin = own_spin ^ flip;
      flipped  = flip;
    end else begin
      new_spin = !(s1_word < iss_pkg::INIT_LIMIT);
      flipped  = 1'b0;
    end
  end

  // own spin of the next site; a one-site grid reads back its own result
  always_ff @(posedge clk) begin
    if (prime_rd) own_spin <= rd_a;
    else if (s1_fire) own_spin <= s1_same ? new_spin : rd_a_eff;
  end

  always_ff @(posedge clk) begin
    if (s1_fire) prev_spin <= new_spin;
  end

  // ---------------- output register ----------------
  logic [iss_pkg::OUT_XY_W-1:0] out_x, out_y;
  logic                         out_spin, out_flip, out_last;

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (s1_fire) out_valid <= 1'b1;
    else if (out_ch.ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_x    <= iss_pkg::OUT_XY_W'(s1_x);
      out_y    <= iss_pkg::OUT_XY_W'(s1_y);
      out_spin <= new_spin;
      out_flip <= flipped;
      out_last <= s1_row_end && s1_col_end;
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.site_x        = out_x;
  assign out_ch.site_y        = out_y;
  assign out_ch.spin_up       = out_spin;
  assign out_ch.flipped       = out_flip;
  assign out_ch.last_of_sweep = out_last;

  // ---------------- assertions ----------------
  `ISS_ASSERT(a_cursor_x, (cur_x != '0) && (cur_x <= last_x), "cursor column left the interior")
  `ISS_ASSERT(a_cursor_y, (cur_y != '0) && (cur_y <= last_y), "cursor row left the interior")
  `ISS_ASSERT(a_accept_slot, in_fire |-> primed && (!s1_valid || s1_fire), "request taken while stage 1 busy")
  `ISS_ASSERT(a_result_lands, s1_fire |=> out_valid, "stage 1 result lost")
  `ISS_ASSERT(a_s1_holds, s1_valid && !s1_fire |=> s1_valid && $stable(s1_x) && $stable(s1_y), "stalled site changed")
  `ISS_ASSERT_RST(a_reset_clear, rst |=> !s1_valid && !out_valid && !primed, "reset left work in flight")

endmodule

`default_nettype wire

// ===== sim/ising_spin_sweep_tb.sv =====
// ising_spin_sweep_tb.sv
// Self-checking bench for the Ising spin sweep: APB setup, random request and result
// stalls, and a scoreboard against a behavioral model. Depends on iss_pkg and the interfaces.
`timescale 1ns / 1ps

module ising_spin_sweep_tb;

  localparam int GRID_MAX    = 1024;
  localparam int ITEMS_TOTAL = 900;

  typedef struct packed {
    logic [iss_pkg::OUT_XY_W-1:0] site_x;
    logic [iss_pkg::OUT_XY_W-1:0] site_y;
    logic                         spin_up;
    logic                         flipped;
    logic                         last_of_sweep;
  } site_t;

  // one row of the directed stimulus: a register write or a request
  typedef struct packed {
    logic                          is_cfg;
    logic [iss_pkg::REG_IDX_W-1:0] reg_idx;
    logic [31:0]                   value;    // register value, or the random word of a request
    logic                          cmd;
    logic                          typed;    // want holds a hand-written expectation
    site_t                         want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [iss_pkg::CFG_ADDR_W-1:0] paddr;
  logic [iss_pkg::CFG_DATA_W-1:0] pwdata;
  logic [iss_pkg::CFG_DATA_W-1:0] prdata;
  logic pready;

  iss_in_if  visit_req();
  iss_out_if visit_res();

  ising_spin_sweep #(
    .MAX_WIDTH (GRID_MAX),
    .MAX_HEIGHT(GRID_MAX)
  ) DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (visit_req),
    .out_ch (visit_res),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model state: stored spins, which sites hold a value, cursor and registers
  bit spin_mirror [GRID_MAX*GRID_MAX];
  bit spin_written [GRID_MAX*GRID_MAX];
  int unsigned cursor_col;
  int unsigned cursor_row;
  logic [iss_pkg::SIZE_W-1:0] width_reg;
  logic [iss_pkg::SIZE_W-1:0] height_reg;
  logic [iss_pkg::THR_W-1:0] zero_thr_reg;
  logic [iss_pkg::THR_W-1:0] border_thr_reg;
  logic [iss_pkg::THR_W-1:0] spont_thr_reg;

  site_t pending_sites[$];
  stim_row_t stim_rows[$];
  int unsigned mismatches = 0;
  int unsigned sent_total = 0;
  int unsigned results_seen = 0;

  function automatic int unsigned clamp_dim(logic [iss_pkg::SIZE_W-1:0] v);
    if (v < 3) return 3;
    if (v > GRID_MAX) return GRID_MAX;
    return v;
  endfunction

  function automatic void align_cursor(int unsigned w, int unsigned h);
    if (cursor_col < 1 || cursor_col > w - 2) cursor_col = 1;
    if (cursor_row < 1 || cursor_row > h - 2) cursor_row = 1;
  endfunction

  function automatic bit on_border(int unsigned x, int unsigned y, int unsigned w,
                                   int unsigned h);
    return x == 0 || y == 0 || x >= w - 1 || y >= h - 1;
  endfunction

  function automatic int spin_val(int unsigned x, int unsigned y, int unsigned w,
                                  int unsigned h);
    if (on_border(x, y, w, h)) return 1;
    return spin_mirror[y*GRID_MAX + x] ? 1 : -1;
  endfunction

  function automatic bit settled(int unsigned x, int unsigned y, int unsigned w,
                                 int unsigned h);
    return on_border(x, y, w, h) || spin_written[y*GRID_MAX + x];
  endfunction

  // an update may only touch a site whose own spin and interior neighbors were set
  function automatic bit update_allowed();
    int unsigned w, h, x, y;
    w = clamp_dim(width_reg);
    h = clamp_dim(height_reg);
    align_cursor(w, h);
    x = cursor_col;
    y = cursor_row;
    return settled(x, y, w, h) && settled(x, y - 1, w, h) && settled(x, y + 1, w, h) &&
           settled(x - 1, y, w, h) && settled(x + 1, y, w, h);
  endfunction

  function automatic void mirror_register(logic [iss_pkg::REG_IDX_W-1:0] idx,
                                          logic [31:0] value);
    case (idx)
      iss_pkg::REG_GRID_WIDTH: begin
        width_reg = value[iss_pkg::SIZE_W-1:0];
        cursor_col = 1;
        cursor_row = 1;
      end
      iss_pkg::REG_GRID_HEIGHT: begin
        height_reg = value[iss_pkg::SIZE_W-1:0];
        cursor_col = 1;
        cursor_row = 1;
      end
      iss_pkg::REG_ZERO_THR: zero_thr_reg = value;
      iss_pkg::REG_BORDER_THR: border_thr_reg = value;
      iss_pkg::REG_SPONT_THR: spont_thr_reg = value;
      default: ;
    endcase
  endfunction

  // visit the site under the cursor, update the stored spin, return what the block reports
  function automatic site_t metropolis_visit(logic cmd, logic [iss_pkg::WORD_W-1:0] word);
    int unsigned w, h, x, y, idx;
    int s, e;
    logic [iss_pkg::THR_W-1:0] thr;
    logic flip, up, last;
    site_t r;
    w = clamp_dim(width_reg);
    h = clamp_dim(height_reg);
    align_cursor(w, h);
    x = cursor_col;
    y = cursor_row;
    idx = y*GRID_MAX + x;
    flip = 1'b0;
    last = 1'b0;
    if (cmd == iss_pkg::CMD_INIT) begin
      up = (word >= iss_pkg::INIT_LIMIT);
    end else begin
      s = spin_mirror[idx] ? 1 : -1;
      e = s * (spin_val(x, y - 1, w, h) + spin_val(x, y + 1, w, h) +
               spin_val(x - 1, y, w, h) + spin_val(x + 1, y, w, h));
      if (e < 0) begin
        flip = 1'b1;
      end else begin
        thr = (e == 0) ? zero_thr_reg : (e == 2) ? border_thr_reg : spont_thr_reg;
        flip = (word < thr);
      end
      up = (s > 0) ^ flip;
    end
    spin_mirror[idx] = up;
    spin_written[idx] = 1'b1;
    cursor_col = x + 1;
    if (cursor_col > w - 2) begin
      cursor_col = 1;
      cursor_row = y + 1;
      if (cursor_row > h - 2) begin
        cursor_row = 1;
        last = 1'b1;
      end
    end
    r.site_x = iss_pkg::OUT_XY_W'(x);
    r.site_y = iss_pkg::OUT_XY_W'(y);
    r.spin_up = up;
    r.flipped = flip;
    r.last_of_sweep = last;
    return r;
  endfunction

  function automatic logic [iss_pkg::THR_W-1:0] draw_threshold();
    case ($urandom_range(0, 4))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      default: return $urandom();
    endcase
  endfunction

  // mostly uniform words, some sitting right on a decision boundary
  function automatic logic [iss_pkg::WORD_W-1:0] draw_word();
    int unsigned pick;
    logic [iss_pkg::WORD_W-1:0] base;
    pick = $urandom_range(0, 15);
    if (pick == 4) return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
    if (pick > 4) return $urandom();
    case (pick)
      0: base = iss_pkg::INIT_LIMIT;
      1: base = zero_thr_reg;
      2: base = border_thr_reg;
      default: base = spont_thr_reg;
    endcase
    return base + $urandom_range(0, 2) - 32'd1;
  endfunction

  function automatic stim_row_t reg_row(logic [iss_pkg::REG_IDX_W-1:0] idx,
                                        logic [31:0] value);
    stim_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.reg_idx = idx;
    r.value = value;
    return r;
  endfunction

  function automatic stim_row_t visit_row(logic cmd, logic [iss_pkg::WORD_W-1:0] word);
    stim_row_t r;
    r = '0;
    r.cmd = cmd;
    r.value = word;
    return r;
  endfunction

  function automatic stim_row_t known_row(logic cmd, logic [iss_pkg::WORD_W-1:0] word,
                                          int x, int y, logic up, logic flip, logic last);
    stim_row_t r;
    r = visit_row(cmd, word);
    r.typed = 1'b1;
    r.want = '{site_x: iss_pkg::OUT_XY_W'(x), site_y: iss_pkg::OUT_XY_W'(y), spin_up: up,
               flipped: flip, last_of_sweep: last};
    return r;
  endfunction

  // write, then read back; the bus is left idle at the end
  task automatic write_register(input logic [iss_pkg::REG_IDX_W-1:0] idx,
                                input logic [31:0] value);
    logic [31:0] want;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    mirror_register(idx, value);
    case (idx)
      iss_pkg::REG_GRID_WIDTH: want = 32'(width_reg);
      iss_pkg::REG_GRID_HEIGHT: want = 32'(height_reg);
      iss_pkg::REG_ZERO_THR: want = zero_thr_reg;
      iss_pkg::REG_BORDER_THR: want = border_thr_reg;
      default: want = spont_thr_reg;
    endcase
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== want) begin
      $error("prdata of register %0d: expected %0h, got %0h", idx, want, prdata);
      mismatches++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_request(input logic cmd, input logic [iss_pkg::WORD_W-1:0] word,
                              input logic typed, input site_t want);
    int unsigned gap;
    site_t got;
    gap = (((sent_total / 96) % 4) == 2) ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      visit_req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    visit_req.valid <= 1'b1;
    visit_req.cmd <= cmd;
    visit_req.random_word <= word;
    do @(posedge clk); while (!visit_req.ready);
    got = metropolis_visit(cmd, word);
    pending_sites.push_back(typed ? want : got);
    sent_total++;
  endtask

  task automatic drain();
    visit_req.valid <= 1'b0;
    while (pending_sites.size() != 0) @(posedge clk);
  endtask

  task automatic run_phase(input bit new_size, input logic [31:0] w, input logic [31:0] h,
                           input int unsigned n_items);
    logic cmd;
    drain();
    if (new_size) begin
      write_register(iss_pkg::REG_GRID_WIDTH, w);
      write_register(iss_pkg::REG_GRID_HEIGHT, h);
    end
    write_register(iss_pkg::REG_ZERO_THR, draw_threshold());
    write_register(iss_pkg::REG_BORDER_THR, draw_threshold());
    write_register(iss_pkg::REG_SPONT_THR, draw_threshold());
    repeat (n_items) begin
      // updates only where the neighborhood is defined; the rest re-initializes sites
      cmd = (update_allowed() && $urandom_range(0, 99) < 85) ? iss_pkg::CMD_UPDATE
                                                              : iss_pkg::CMD_INIT;
      send_request(cmd, draw_word(), 1'b0, '0);
    end
  endtask

  initial begin : result_sink
    int unsigned gap;
    site_t want;
    visit_res.ready <= 1'b0;
    do @(posedge clk); while (rst);
    gap = $urandom_range(0, 6);
    forever begin
      if (gap != 0) begin
        visit_res.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      visit_res.ready <= 1'b1;
      do @(posedge clk); while (!visit_res.valid);
      results_seen++;
      if (pending_sites.size() == 0) begin
        $error("result for site (%0d,%0d) with no request outstanding",
               visit_res.site_x, visit_res.site_y);
        mismatches++;
      end else begin
        want = pending_sites.pop_front();
        if (visit_res.site_x !== want.site_x) begin
          $error("site_x: expected %0d, got %0d", want.site_x, visit_res.site_x);
          mismatches++;
        end
        if (visit_res.site_y !== want.site_y) begin
          $error("site_y: expected %0d, got %0d", want.site_y, visit_res.site_y);
          mismatches++;
        end
        if (visit_res.spin_up !== want.spin_up) begin
          $error("spin_up: expected %0b, got %0b", want.spin_up, visit_res.spin_up);
          mismatches++;
        end
        if (visit_res.flipped !== want.flipped) begin
          $error("flipped: expected %0b, got %0b", want.flipped, visit_res.flipped);
          mismatches++;
        end
        if (visit_res.last_of_sweep !== want.last_of_sweep) begin
          $error("last_of_sweep: expected %0b, got %0b", want.last_of_sweep,
                 visit_res.last_of_sweep);
          mismatches++;
        end
      end
      // long hold-offs so the block backs up and stalls its request side
      if ((results_seen % 250) == 0) gap = 200;
      else gap = (((results_seen / 80) % 4) == 1) ? 0 : $urandom_range(0, 6);
    end
  end

  initial begin : stimulus
    int unsigned n;
    logic [31:0] w;
    logic [31:0] h;
    rst <= 1'b1;
    visit_req.valid <= 1'b0;
    visit_req.cmd <= iss_pkg::CMD_INIT;
    visit_req.random_word <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    cursor_col = 1;
    cursor_row = 1;
    width_reg = iss_pkg::SIZE_RESET;
    height_reg = iss_pkg::SIZE_RESET;
    zero_thr_reg = iss_pkg::ZERO_THR_RESET;
    border_thr_reg = iss_pkg::BORDER_THR_RESET;
    spont_thr_reg = iss_pkg::SPONT_THR_RESET;

    // 3x3 grid after reset: a single interior site with four +1 neighbors
    stim_rows.push_back(known_row(iss_pkg::CMD_INIT, 32'h0000_0000, 1, 1, 1'b0, 1'b0, 1'b1));
    stim_rows.push_back(known_row(iss_pkg::CMD_UPDATE, 32'h0000_0000, 1, 1, 1'b1, 1'b1, 1'b1));
    stim_rows.push_back(known_row(iss_pkg::CMD_UPDATE, 32'h0000_0000, 1, 1, 1'b1, 1'b0, 1'b1));
    stim_rows.push_back(known_row(iss_pkg::CMD_INIT, 32'h7FFF_FFFE, 1, 1, 1'b0, 1'b0, 1'b1));
    stim_rows.push_back(known_row(iss_pkg::CMD_INIT, 32'h7FFF_FFFF, 1, 1, 1'b1, 1'b0, 1'b1));
    stim_rows.push_back(known_row(iss_pkg::CMD_INIT, 32'hFFFF_FFFF, 1, 1, 1'b1, 1'b0, 1'b1));
    stim_rows.push_back(reg_row(iss_pkg::REG_SPONT_THR, 32'hFFFF_FFFF));
    stim_rows.push_back(known_row(iss_pkg::CMD_UPDATE, 32'hFFFF_FFFE, 1, 1, 1'b0, 1'b1, 1'b1));
    stim_rows.push_back(known_row(iss_pkg::CMD_UPDATE, 32'hFFFF_FFFF, 1, 1, 1'b1, 1'b1, 1'b1));
    stim_rows.push_back(known_row(iss_pkg::CMD_UPDATE, 32'hFFFF_FFFF, 1, 1, 1'b1, 1'b0, 1'b1));
    // sizes below the minimum and above the maximum saturate
    stim_rows.push_back(reg_row(iss_pkg::REG_GRID_WIDTH, 32'd0));
    stim_rows.push_back(known_row(iss_pkg::CMD_INIT, 32'h8000_0000, 1, 1, 1'b1, 1'b0, 1'b1));
    stim_rows.push_back(reg_row(iss_pkg::REG_GRID_HEIGHT, 32'd2047));
    stim_rows.push_back(known_row(iss_pkg::CMD_INIT, 32'h0000_0000, 1, 1, 1'b0, 1'b0, 1'b0));
    stim_rows.push_back(known_row(iss_pkg::CMD_INIT, 32'hFFFF_FFFF, 1, 2, 1'b1, 1'b0, 1'b0));
    // 4x4 grid: interior neighbors give the e = 0 and e = 2 cases
    stim_rows.push_back(reg_row(iss_pkg::REG_GRID_WIDTH, 32'd4));
    stim_rows.push_back(reg_row(iss_pkg::REG_GRID_HEIGHT, 32'd4));
    stim_rows.push_back(reg_row(iss_pkg::REG_ZERO_THR, 32'h8000_0000));
    stim_rows.push_back(reg_row(iss_pkg::REG_BORDER_THR, 32'hFFFF_FFFF));
    stim_rows.push_back(known_row(iss_pkg::CMD_INIT, 32'h0000_0000, 1, 1, 1'b0, 1'b0, 1'b0));
    stim_rows.push_back(known_row(iss_pkg::CMD_INIT, 32'hFFFF_FFFF, 2, 1, 1'b1, 1'b0, 1'b0));
    stim_rows.push_back(known_row(iss_pkg::CMD_INIT, 32'h7FFF_FFFE, 1, 2, 1'b0, 1'b0, 1'b0));
    stim_rows.push_back(known_row(iss_pkg::CMD_INIT, 32'h7FFF_FFFF, 2, 2, 1'b1, 1'b0, 1'b1));
    stim_rows.push_back(visit_row(iss_pkg::CMD_UPDATE, 32'h0000_0000));
    stim_rows.push_back(visit_row(iss_pkg::CMD_UPDATE, 32'h7FFF_FFFF));
    stim_rows.push_back(visit_row(iss_pkg::CMD_UPDATE, 32'h8000_0000));
    stim_rows.push_back(visit_row(iss_pkg::CMD_UPDATE, 32'hFFFF_FFFE));

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_rows[i]) begin
      if (stim_rows[i].is_cfg) begin
        drain();
        write_register(stim_rows[i].reg_idx, stim_rows[i].value);
      end else begin
        send_request(stim_rows[i].cmd, stim_rows[i].value, stim_rows[i].typed,
                     stim_rows[i].want);
      end
    end

    // widest and tallest saturated grids: the start of a pass each
    run_phase(1'b1, 32'd2047, 32'd3, 48);
    run_phase(1'b1, 32'd3, 32'd1024, 48);

    while (sent_total < ITEMS_TOTAL) begin
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 14);
      h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
      n = $urandom_range(40, 120);
      if (n > ITEMS_TOTAL - sent_total) n = ITEMS_TOTAL - sent_total;
      run_phase($urandom_range(0, 3) != 0, w, h, n);
    end

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // slowest run is well under a millisecond of simulated time
  initial begin : watchdog
    #5ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
